[sv/mts_pkg.sv]
// Package for the min-tracking stack: sizes, operation and fault codes,
// controller state and the memory request bundle. No dependencies.
package mts_pkg;

  // Stack geometry
  localparam int STACK_DEPTH = 64;
  localparam int VALUE_WIDTH = 32;
  localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(STACK_DEPTH);

  // Stream word widths, padded to whole bytes
  localparam int IN_TDATA_W  = ((VALUE_WIDTH + 7) / 8) * 8;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = ((2 * VALUE_WIDTH + 7) / 8) * 8;
  localparam int OUT_TUSER_W = 3;

  typedef enum logic [1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_PEEK = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    FAULT_OK        = 2'd0,
    FAULT_UNDERFLOW = 2'd1,
    FAULT_OVERFLOW  = 2'd2
  } fault_e;

  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_FETCH = 1'b1
  } state_e;

  // One write port and one read port of a stack memory
  typedef struct packed {
    logic                   we;
    logic [ADDR_W-1:0]      waddr;
    logic [VALUE_WIDTH-1:0] wdata;
    logic                   re;
    logic [ADDR_W-1:0]      raddr;
  } ram_req_t;

endpackage

[sv/mts_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered
// read data. No dependencies.
module mts_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port, data registered
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/mts_ctrl.sv]
// Stack controller: counts, registered top copies, memory requests and the
// result register. Depends on mts_pkg; drives two mts_ram instances.
module mts_ctrl
  import mts_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [1:0]             in_op_i,
  input  logic [VALUE_WIDTH-1:0] in_value_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [VALUE_WIDTH-1:0] out_top_o,
  output logic [VALUE_WIDTH-1:0] out_min_o,
  output logic                   out_empty_o,
  output logic [1:0]             out_fault_o,
  output ram_req_t               vram_req_o,
  output ram_req_t               mram_req_o,
  input  logic [VALUE_WIDTH-1:0] vram_rdata_i,
  input  logic [VALUE_WIDTH-1:0] mram_rdata_i
);

  state_e                 state_q, state_d;
  logic [CNT_W-1:0]       vcnt_q, vcnt_d;
  logic [CNT_W-1:0]       mcnt_q, mcnt_d;
  logic [VALUE_WIDTH-1:0] vtop_q, vtop_d;
  logic [VALUE_WIDTH-1:0] mtop_q, mtop_d;
  logic                   out_valid_q, out_valid_d;
  logic [VALUE_WIDTH-1:0] out_top_q, out_top_d;
  logic [VALUE_WIDTH-1:0] out_min_q, out_min_d;
  logic                   out_empty_q, out_empty_d;
  fault_e                 out_fault_q, out_fault_d;

  // Result to load into the output register
  logic                   res_load;
  logic [CNT_W-1:0]       res_vcnt;
  logic [CNT_W-1:0]       res_mcnt;
  logic [VALUE_WIDTH-1:0] res_vtop;
  logic [VALUE_WIDTH-1:0] res_mtop;
  fault_e                 res_fault;

  logic                   accept;
  logic [CNT_W-1:0]       pop_mcnt;

  assign in_ready_o = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;

  // Min stack pops when its top matches the value leaving the value stack
  assign pop_mcnt = ((mcnt_q != '0) && (mtop_q == vtop_q)) ? (mcnt_q - CNT_W'(1)) : mcnt_q;

  // Next state, memory requests and result
  always_comb begin
    state_d     = state_q;
    vcnt_d      = vcnt_q;
    mcnt_d      = mcnt_q;
    vtop_d      = vtop_q;
    mtop_d      = mtop_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_top_d   = out_top_q;
    out_min_d   = out_min_q;
    out_empty_d = out_empty_q;
    out_fault_d = out_fault_q;
    vram_req_o  = '0;
    mram_req_o  = '0;
    res_load    = 1'b0;
    res_vcnt    = vcnt_q;
    res_mcnt    = mcnt_q;
    res_vtop    = vtop_q;
    res_mtop    = mtop_q;
    res_fault   = FAULT_OK;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (op_e'(in_op_i))
            OP_PUSH: begin
              res_load = 1'b1;
              if (vcnt_q == FULL_CNT) begin
                res_fault = FAULT_OVERFLOW;
              end else begin
                // Store the word and update the value top
                vram_req_o.we    = 1'b1;
                vram_req_o.waddr = vcnt_q[ADDR_W-1:0];
                vram_req_o.wdata = in_value_i;
                vcnt_d   = vcnt_q + CNT_W'(1);
                vtop_d   = in_value_i;
                res_vcnt = vcnt_d;
                res_vtop = in_value_i;
                // New minimum candidate
                if (((mcnt_q == '0) || ($signed(in_value_i) <= $signed(mtop_q)))
                    && (mcnt_q != FULL_CNT)) begin
                  mram_req_o.we    = 1'b1;
                  mram_req_o.waddr = mcnt_q[ADDR_W-1:0];
                  mram_req_o.wdata = in_value_i;
                  mcnt_d   = mcnt_q + CNT_W'(1);
                  mtop_d   = in_value_i;
                  res_mcnt = mcnt_d;
                  res_mtop = in_value_i;
                end
              end
            end
            OP_POP: begin
              if (vcnt_q == '0) begin
                res_load  = 1'b1;
                res_fault = FAULT_UNDERFLOW;
              end else begin
                // Drop the tops and fetch the entries below them
                vcnt_d           = vcnt_q - CNT_W'(1);
                mcnt_d           = pop_mcnt;
                vram_req_o.re    = 1'b1;
                vram_req_o.raddr = ADDR_W'(vcnt_q - CNT_W'(2));
                mram_req_o.re    = 1'b1;
                mram_req_o.raddr = ADDR_W'(pop_mcnt - CNT_W'(1));
                state_d          = ST_FETCH;
              end
            end
            default: begin
              // Peek, and the unused code
              res_load = 1'b1;
            end
          endcase
        end
      end
      ST_FETCH: begin
        // Refill the top copies from memory
        vtop_d   = vram_rdata_i;
        mtop_d   = mram_rdata_i;
        res_load = 1'b1;
        res_vtop = vram_rdata_i;
        res_mtop = mram_rdata_i;
        state_d  = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (res_load) begin
      out_valid_d = 1'b1;
      out_top_d   = (res_vcnt != '0) ? res_vtop : '0;
      out_min_d   = ((res_vcnt != '0) && (res_mcnt != '0)) ? res_mtop : '0;
      out_empty_d = (res_vcnt == '0);
      out_fault_d = res_fault;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      vcnt_q      <= '0;
      mcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      vcnt_q      <= vcnt_d;
      mcnt_q      <= mcnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    vtop_q      <= vtop_d;
    mtop_q      <= mtop_d;
    out_top_q   <= out_top_d;
    out_min_q   <= out_min_d;
    out_empty_q <= out_empty_d;
    out_fault_q <= out_fault_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_top_o   = out_top_q;
  assign out_min_o   = out_min_q;
  assign out_empty_o = out_empty_q;
  assign out_fault_o = out_fault_q;

`ifndef ASSERT_OFF
  a_min_cnt_le: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mcnt_q <= vcnt_q)
    else $error("min stack deeper than value stack");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vcnt_q <= FULL_CNT)
    else $error("value count beyond depth");

  a_fetch_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FETCH) |-> !out_valid_q)
    else $error("result register busy during fetch");

  a_pop_fetch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (in_op_i == OP_POP) && (vcnt_q != '0)) |=> (state_q == ST_FETCH))
    else $error("pop did not enter fetch");

  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (in_op_i == OP_POP) && (vcnt_q != '0))
      |=> (vcnt_q == $past(vcnt_q) - CNT_W'(1)))
    else $error("pop did not decrement count");
`endif

endmodule

[sv/min_tracking_stack.sv]
// Top level of the min-tracking stack: stream ports, word packing, the
// controller and the value and minimum memories. Depends on mts_pkg.
//
//  channel  | dir | tdata                    | tuser
//  s_axis   | in  | value                    | operation
//  m_axis   | out | top_value, min_value     | is_empty, fault
//
// Push, peek and faulting pop: result registered in the cycle after accept.
// Successful pop: a further ST_FETCH state waits on the memory read of the
// new tops. A new word is taken once the controller is idle and the result
// register is empty or draining. Reset clears the counts, the controller
// state and the result valid flag; the memories are not cleared and need no
// clearing pass. Stalls on m_axis hold the result.
module min_tracking_stack
  import mts_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,  // value
  input  logic [IN_TUSER_W-1:0]  s_axis_tuser_i,  // operation
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,  // top_value, min_value
  output logic [OUT_TUSER_W-1:0] m_axis_tuser_o   // is_empty, fault
);

  ram_req_t               vram_req;
  ram_req_t               mram_req;
  logic [VALUE_WIDTH-1:0] vram_rdata;
  logic [VALUE_WIDTH-1:0] mram_rdata;
  logic [VALUE_WIDTH-1:0] out_top;
  logic [VALUE_WIDTH-1:0] out_min;
  logic                   out_empty;
  logic [1:0]             out_fault;

  mts_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .in_op_i      (s_axis_tuser_i),
    .in_value_i   (s_axis_tdata_i[VALUE_WIDTH-1:0]),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_top_o    (out_top),
    .out_min_o    (out_min),
    .out_empty_o  (out_empty),
    .out_fault_o  (out_fault),
    .vram_req_o   (vram_req),
    .mram_req_o   (mram_req),
    .vram_rdata_i (vram_rdata),
    .mram_rdata_i (mram_rdata)
  );

  // Value stack memory
  mts_ram #(
    .DEPTH (STACK_DEPTH),
    .WIDTH (VALUE_WIDTH)
  ) u_vram (
    .clk_i   (clk_i),
    .we_i    (vram_req.we),
    .waddr_i (vram_req.waddr),
    .wdata_i (vram_req.wdata),
    .re_i    (vram_req.re),
    .raddr_i (vram_req.raddr),
    .rdata_o (vram_rdata)
  );

  // Minimum candidate memory
  mts_ram #(
    .DEPTH (STACK_DEPTH),
    .WIDTH (VALUE_WIDTH)
  ) u_mram (
    .clk_i   (clk_i),
    .we_i    (mram_req.we),
    .waddr_i (mram_req.waddr),
    .wdata_i (mram_req.wdata),
    .re_i    (mram_req.re),
    .raddr_i (mram_req.raddr),
    .rdata_o (mram_rdata)
  );

  // Pack the result word, zero padded
  assign m_axis_tdata_o = OUT_TDATA_W'({out_min, out_top});
  assign m_axis_tuser_o = {out_fault, out_empty};

endmodule

[tb/sv/mts_result_checker.sv]
`timescale 1ns / 1ps
// Result checker for the min-tracking stack: tracks both stream channels, predicts
// each result word from the accepted input words and compares it field by field.
// Depends on mts_pkg.
module mts_result_checker
  import mts_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  input  logic                   s_axis_tready_i,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,  // value
  input  logic [IN_TUSER_W-1:0]  s_axis_tuser_i,  // operation
  input  logic                   m_axis_tvalid_i,
  input  logic                   m_axis_tready_i,
  input  logic [OUT_TDATA_W-1:0] m_axis_tdata_i,  // top_value, min_value
  input  logic [OUT_TUSER_W-1:0] m_axis_tuser_i,  // is_empty, fault
  output int                     fail_count_o,
  output int                     pending_o
);

  typedef logic signed [VALUE_WIDTH-1:0] value_t;

  typedef struct {
    value_t     top_value;
    value_t     min_value;
    logic       is_empty;
    logic [1:0] fault;
  } stack_view_t;

  // Shadow copy of the value stack and of the minimum candidates
  value_t      values_q[$];
  value_t      mins_q[$];
  // Predicted result words, oldest first
  stack_view_t due_q[$];

  int fails   = 0;
  int pending = 0;

  assign fail_count_o = fails;
  assign pending_o    = pending;

  // Apply one operation to the shadow stacks and return the view it leaves
  function automatic stack_view_t apply_stack_op(input logic [1:0] op, input value_t value);
    stack_view_t view;
    value_t      popped;
    view.fault = FAULT_OK;
    case (op)
      OP_PUSH: begin
        if (values_q.size() >= STACK_DEPTH) begin
          view.fault = FAULT_OVERFLOW;
        end else begin
          if ((mins_q.size() == 0 || value <= mins_q[$]) && mins_q.size() < STACK_DEPTH)
            mins_q.push_back(value);
          values_q.push_back(value);
        end
      end
      OP_POP: begin
        if (values_q.size() == 0) begin
          view.fault = FAULT_UNDERFLOW;
        end else begin
          popped = values_q.pop_back();
          if (mins_q.size() > 0 && mins_q[$] == popped)
            void'(mins_q.pop_back());
        end
      end
      // peek and the spare code leave the stacks alone
      default: ;
    endcase
    view.is_empty  = (values_q.size() == 0);
    view.top_value = view.is_empty ? value_t'(0) : values_q[$];
    view.min_value = (!view.is_empty && mins_q.size() > 0) ? mins_q[$] : value_t'(0);
    return view;
  endfunction

  task automatic check_field(input string name, input logic signed [63:0] want,
                             input logic signed [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      fails++;
    end
  endtask

  // Compare each result word, then predict for each accepted input word
  always @(posedge clk_i) begin : watch
    stack_view_t want;
    stack_view_t got;
    if (rst_ni) begin
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got.top_value = m_axis_tdata_i[VALUE_WIDTH-1:0];
        got.min_value = m_axis_tdata_i[2*VALUE_WIDTH-1:VALUE_WIDTH];
        got.is_empty  = m_axis_tuser_i[0];
        got.fault     = m_axis_tuser_i[2:1];
        if (due_q.size() == 0) begin
          $display("%0t: result word with none expected: top %0d min %0d empty %0d fault %0d",
                   $time, got.top_value, got.min_value, got.is_empty, got.fault);
          fails++;
        end else begin
          want = due_q.pop_front();
          check_field("top_value", want.top_value, got.top_value);
          check_field("min_value", want.min_value, got.min_value);
          check_field("is_empty", {63'd0, want.is_empty}, {63'd0, got.is_empty});
          check_field("fault", {62'd0, want.fault}, {62'd0, got.fault});
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i)
        due_q.push_back(apply_stack_op(s_axis_tuser_i, s_axis_tdata_i[VALUE_WIDTH-1:0]));
      pending <= due_q.size();
    end
  end

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// Testbench top for the min-tracking stack: clock, reset, stream stimulus with
// random idling, watchdog and verdict. Depends on mts_pkg, min_tracking_stack
// and mts_result_checker.
module tb_top;
  import mts_pkg::*;

  localparam logic [1:0] OP_SPARE     = 2'd3;
  localparam int         IDLE_PCT     = 18;
  localparam int         RANDOM_ITEMS = 1050;
  localparam int         STALL_LIMIT  = 4000;
  localparam int         DRAIN_CYCLES = 8;

  localparam logic [VALUE_WIDTH-1:0] VAL_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  localparam logic [VALUE_WIDTH-1:0] VAL_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

  typedef enum logic [1:0] {MODE_FILL, MODE_DRAIN, MODE_MIXED} traffic_e;

  logic                   clk;
  logic                   rst_n    = 1'b0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata  = '0;
  logic [IN_TUSER_W-1:0]  s_tuser  = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic [OUT_TUSER_W-1:0] m_tuser;
  logic                   quiet    = 1'b0;
  int                     fail_count;
  int                     pending;
  int                     idle_cycles = 0;

  min_tracking_stack u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  mts_result_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_i (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_i (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_i  (m_tdata),
    .m_axis_tuser_i  (m_tuser),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Stall the result channel at random, never during a quiet stretch
  always @(posedge clk) begin
    m_tready <= quiet || ($urandom_range(99) >= IDLE_PCT);
  end

  // End the run when no word moves on either channel for too long
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("min_tracking_stack test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offer one word, with random idle cycles ahead of it, and hold until taken
  task automatic send_word(input logic [1:0] op, input logic [VALUE_WIDTH-1:0] value);
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      s_tdata  <= IN_TDATA_W'($urandom);
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= IN_TDATA_W'(value);
    s_tuser  <= op;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Mostly full-range values, with extremes and a narrow band to force ties
  function automatic logic [VALUE_WIDTH-1:0] pick_value();
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(4))
          0:       return VAL_MIN;
          1:       return VAL_MAX;
          2:       return '1;
          3:       return '0;
          default: return VALUE_WIDTH'(1);
        endcase
      end
      1, 2, 3: return VALUE_WIDTH'(int'($urandom_range(8)) - 4);
      default: return VALUE_WIDTH'({$urandom, $urandom});
    endcase
  endfunction

  function automatic logic [1:0] pick_op(input traffic_e mode);
    int r;
    r = $urandom_range(99);
    case (mode)
      MODE_FILL:  return (r < 88) ? OP_PUSH : (r < 95) ? OP_POP : (r < 98) ? OP_PEEK : OP_SPARE;
      MODE_DRAIN: return (r < 85) ? OP_POP : (r < 95) ? OP_PUSH : OP_PEEK;
      default:    return (r < 45) ? OP_PUSH : (r < 80) ? OP_POP : (r < 93) ? OP_PEEK : OP_SPARE;
    endcase
  endfunction

  initial begin
    int       sent;
    int       seg;
    int       seg_len;
    traffic_e mode;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty stack: underflow, peek and the spare code
    send_word(OP_POP, '0);
    send_word(OP_PEEK, '1);
    send_word(OP_SPARE, VAL_MAX);
    // Extremes and a repeated minimum
    send_word(OP_PUSH, VAL_MAX);
    send_word(OP_PUSH, VAL_MIN);
    send_word(OP_PUSH, VAL_MIN);
    send_word(OP_PUSH, '0);
    send_word(OP_PEEK, VAL_MIN);
    send_word(OP_SPARE, '1);
    // Unwind: the tied minimum leaves one candidate at a time
    send_word(OP_POP, VAL_MAX);
    send_word(OP_POP, '0);
    send_word(OP_POP, '1);
    send_word(OP_POP, '0);
    send_word(OP_POP, '0);
    // Small values with a tie below the top
    send_word(OP_PUSH, '1);
    send_word(OP_PUSH, VALUE_WIDTH'(5));
    send_word(OP_PUSH, '1);
    send_word(OP_PUSH, VALUE_WIDTH'(-7));
    repeat (5) send_word(OP_POP, '0);

    // Random traffic in segments; the first fills past capacity
    sent = 0;
    seg  = 0;
    while (sent < RANDOM_ITEMS) begin
      mode    = (seg == 0) ? MODE_FILL : (seg == 1) ? MODE_DRAIN
                                        : traffic_e'($urandom_range(2));
      seg_len = (seg == 0) ? 110 : (seg == 3) ? 150 : $urandom_range(30, 110);
      quiet  <= (seg == 3);
      repeat (seg_len) send_word(pick_op(mode), pick_value());
      sent += seg_len;
      // After the first segment, and after others at random, hold off until every result is back
      if (seg == 0 || $urandom_range(3) == 0) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      seg++;
    end

    s_tvalid <= 1'b0;
    quiet    <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("min_tracking_stack test passed");
    else
      $display("min_tracking_stack test failed");
    $finish;
  end

endmodule
